// File: hw/rtl/sczc_pkg.sv
// Package for the scan collision zone check: constants, payload types and
// the sine and cosine tables, which are built at elaboration.
// Depends on nothing; every RTL file of the block uses it.
package sczc_pkg;

   localparam int SCAN_POINTS    = 181;
   localparam int RANGE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 15;

   localparam int RANGE_W    = 16;
   localparam int IDX_W      = 10;
   localparam int X_W        = 17;
   localparam int TRIG_W     = TRIG_FRAC_BITS + 2;
   localparam int PROD_W     = RANGE_W + TRIG_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SCAN_LAST   = SCAN_POINTS - 1;
   localparam int HALF_POINTS = SCAN_LAST / 2;
   localparam int FOLD_W      = (HALF_POINTS > 0) ? $clog2(HALF_POINTS + 1) : 1;

   localparam logic [RANGE_W-1:0] RANGE_MASK = (RANGE_BITS >= RANGE_W) ?
      {RANGE_W{1'b1}} : RANGE_W'((64'd1 << RANGE_BITS) - 64'd1);

   localparam logic [63:0] PI_Q30       = 64'd3373259426;
   localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
   localparam int          SERIES_TERMS = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VEHICLE_WIDTH = 2'd0,
      CSR_STOP_DISTANCE = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_sample;
      logic               last_sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [X_W-1:0] x_coord;
      logic [RANGE_W-1:0]    y_coord;
      logic [IDX_W-1:0]      sample_index;
      logic                  stop_flag;
      logic [IDX_W-1:0]      hit_index;
      logic                  scan_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [RANGE_W-1:0] range_sample;
      logic               last_sample;
      logic [IDX_W-1:0]   sample_index;
      logic [FOLD_W-1:0]  fold_index;
      logic               neg_cos;
   } stage_type;

   typedef struct packed {
      logic signed [X_W-1:0] x_coord;
      logic [RANGE_W-1:0]    y_coord;
      logic [X_W-1:0]        x_mag;
   } geom_type;

   typedef logic [TRIG_W-1:0] trig_table_type [0:HALF_POINTS];

   // Restoring division; it only runs while the tables are built.
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] series_q30(logic [63:0] a, logic odd);
      logic [63:0]        a2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        n;
      a2   = (a * a) >> 30;
      term = odd ? a : ONE_Q30;
      sum  = $signed(term);
      n    = odd ? 64'd1 : 64'd0;
      for (int k = 1; k < SERIES_TERMS; k++) begin
         term = (term * a2) >> 30;
         term = div_u64(term, (n + 64'd1) * (n + 64'd2));
         n    = n + 64'd2;
         if (k[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      return $unsigned(sum);
   endfunction

   function automatic logic [TRIG_W-1:0] to_frac(logic [63:0] q30);
      logic [63:0] v;
      v = (q30 + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      return v[TRIG_W-1:0];
   endfunction

   function automatic trig_table_type build_table(logic odd);
      trig_table_type t;
      logic [63:0]    a;
      for (int j = 0; j <= HALF_POINTS; j++) begin
         a    = div_u64(PI_Q30 * 64'(j) + 64'(HALF_POINTS), 64'(SCAN_LAST));
         t[j] = to_frac(series_q30(a, odd));
      end
      return t;
   endfunction

   localparam trig_table_type SIN_TABLE = build_table(1'b1);
   localparam trig_table_type COS_TABLE = build_table(1'b0);

endpackage

// File: hw/rtl/sczc_geom.sv
// Polar to Cartesian conversion of one range sample: table lookup of the
// folded angle, two multiplies and half-up rounding. Uses sczc_pkg.
module sczc_geom (
   input  sczc_pkg::stage_type stage,
   output sczc_pkg::geom_type  geom
);

   logic [sczc_pkg::TRIG_W-1:0]  sin_val;
   logic [sczc_pkg::TRIG_W-1:0]  cos_val;
   logic [sczc_pkg::PROD_W-1:0]  x_prod;
   logic [sczc_pkg::PROD_W-1:0]  y_prod;
   logic [sczc_pkg::PROD_W:0]    x_sum;
   logic [sczc_pkg::PROD_W:0]    y_sum;
   logic [sczc_pkg::X_W-1:0]     x_mag;
   localparam logic [sczc_pkg::PROD_W:0] ROUND_HALF =
      (sczc_pkg::PROD_W + 1)'(64'd1 << (sczc_pkg::TRIG_FRAC_BITS - 1));

   always_comb begin
      sin_val = sczc_pkg::SIN_TABLE[stage.fold_index];
      cos_val = sczc_pkg::COS_TABLE[stage.fold_index];
      x_prod  = sczc_pkg::PROD_W'(stage.range_sample) * sczc_pkg::PROD_W'(cos_val);
      y_prod  = sczc_pkg::PROD_W'(stage.range_sample) * sczc_pkg::PROD_W'(sin_val);
      x_sum   = {1'b0, x_prod} + ROUND_HALF;
      y_sum   = {1'b0, y_prod} + ROUND_HALF;
      x_mag   = x_sum[sczc_pkg::TRIG_FRAC_BITS +: sczc_pkg::X_W];
      geom.x_mag   = x_mag;
      geom.y_coord = y_sum[sczc_pkg::TRIG_FRAC_BITS +: sczc_pkg::RANGE_W];
      geom.x_coord = stage.neg_cos ? -$signed(x_mag) : $signed(x_mag);
   end

endmodule

// File: hw/rtl/scan_collision_zone_check.sv
// Top level of the scan collision zone check: index counter, input stage,
// zone test, first-hit latch and result register. Uses sczc_pkg, sczc_geom.
//
// Each word on the req channel is one range sample of a 180-degree scan.
// The block numbers samples in arrival order, converts the range to x and y
// and tests the point against the zone set by the csr registers. Each word
// on the rsp channel carries x, y, the sample index, the running stop
// verdict, the first hit index and the scan end mark. A word with
// last_sample set closes the scan and clears the counter and the latch.
// A word passes two registers, the input stage and the result register;
// rsp_valid rises when the result register takes it. One word is accepted
// per cycle unless the receiver stalls; throughput is one word per cycle, set
// by one pass through the table lookup, the multipliers and the zone compare.
// When the receiver stalls, the result register holds its word and the
// input stage takes one more word before req_stall rises.
// Synchronous reset empties both stages, clears the counter and the latch
// and sets both zone registers to zero.
module scan_collision_zone_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sczc_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sczc_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_write_enable,
   input  logic [sczc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sczc_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [sczc_pkg::RANGE_W-1:0] width_ff, width_in;
   logic [sczc_pkg::RANGE_W-1:0] stop_ff, stop_in;
   logic [sczc_pkg::IDX_W-1:0]   counter_ff, counter_in;
   logic                         s1_valid_ff, s1_valid_in;
   sczc_pkg::stage_type          s1_ff, s1_in;
   logic                         out_valid_ff, out_valid_in;
   sczc_pkg::rsp_payload_type    rsp_ff, rsp_in;
   logic                         seen_ff, seen_in;
   logic [sczc_pkg::IDX_W-1:0]   first_ff, first_in;

   sczc_pkg::geom_type           geom;
   logic                         s1_move;
   logic                         req_take;
   logic                         hit;
   logic                         seen_now;
   logic [sczc_pkg::IDX_W-1:0]   first_now;
   logic                         neg_cos;
   logic [sczc_pkg::IDX_W-1:0]   fold;

   localparam logic [sczc_pkg::IDX_W-1:0] LAST_IDX = sczc_pkg::IDX_W'(sczc_pkg::SCAN_LAST);

   sczc_geom u_geom (
      .stage (s1_ff),
      .geom  (geom)
   );

   assign s1_move   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      width_in = width_ff;
      stop_in  = stop_ff;
      if (csr_write_enable) begin
         if (csr_index == sczc_pkg::CSR_VEHICLE_WIDTH) begin
            width_in = csr_write_data;
         end else if (csr_index == sczc_pkg::CSR_STOP_DISTANCE) begin
            stop_in = csr_write_data;
         end
      end
   end

   always_comb begin
      neg_cos = {1'b0, counter_ff, 1'b0} > (sczc_pkg::IDX_W + 2)'(sczc_pkg::SCAN_LAST);
      fold    = neg_cos ? LAST_IDX - counter_ff : counter_ff;
      s1_in.range_sample = req_payload.range_sample & sczc_pkg::RANGE_MASK;
      s1_in.last_sample  = req_payload.last_sample;
      s1_in.sample_index = counter_ff;
      s1_in.fold_index   = fold[sczc_pkg::FOLD_W-1:0];
      s1_in.neg_cos      = neg_cos;
      counter_in = counter_ff;
      if (req_take) begin
         if (req_payload.last_sample) begin
            counter_in = '0;
         end else if (counter_ff < LAST_IDX) begin
            counter_in = counter_ff + 1'b1;
         end
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      hit = (geom.y_coord < stop_ff) &&
            ({geom.x_mag, 1'b0} < {{(sczc_pkg::X_W + 1 - sczc_pkg::RANGE_W){1'b0}}, width_ff});
      seen_now  = seen_ff || hit;
      first_now = seen_ff ? first_ff : s1_ff.sample_index;
      rsp_in.x_coord      = geom.x_coord;
      rsp_in.y_coord      = geom.y_coord;
      rsp_in.sample_index = s1_ff.sample_index;
      rsp_in.stop_flag    = seen_now;
      rsp_in.hit_index    = seen_now ? first_now : '0;
      rsp_in.scan_done    = s1_ff.last_sample;
      out_valid_in = s1_move ? s1_valid_ff : out_valid_ff;
      seen_in  = seen_ff;
      first_in = first_ff;
      if (s1_valid_ff && s1_move) begin
         if (s1_ff.last_sample) begin
            seen_in  = 1'b0;
            first_in = '0;
         end else begin
            seen_in  = seen_now;
            first_in = first_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= '0;
         stop_ff      <= '0;
         counter_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         first_ff     <= '0;
      end else begin
         width_ff     <= width_in;
         stop_ff      <= stop_in;
         counter_ff   <= counter_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
      if (s1_valid_ff && s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: dv/testbench.sv
// Self-checking testbench for scan_collision_zone_check: random and directed scans,
// a prediction of every result word, and randomized sender and receiver pacing.
// Depends on sczc_pkg and the scan_collision_zone_check RTL.
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 20;
   localparam int PHASES      = 7;
   localparam logic [sczc_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [sczc_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   class zone_scoreboard;
      logic [sczc_pkg::TRIG_W-1:0] sin_lut [0:sczc_pkg::HALF_POINTS];
      logic [sczc_pkg::TRIG_W-1:0] cos_lut [0:sczc_pkg::HALF_POINTS];
      logic [15:0]                 lane_width;
      logic [15:0]                 stop_dist;
      logic [sczc_pkg::IDX_W-1:0]  step_count;
      logic [sczc_pkg::IDX_W-1:0]  first_hit_idx;
      logic                        hit_latched;
      sczc_pkg::rsp_payload_type   expected_q [$];
      int                          errors;
      int                          words_in;

      function new();
         logic [63:0] angle;
         for (int j = 0; j <= sczc_pkg::HALF_POINTS; j++) begin
            angle = (sczc_pkg::PI_Q30 * 64'(j) + 64'(sczc_pkg::SCAN_LAST / 2)) /
                    64'(sczc_pkg::SCAN_LAST);
            sin_lut[j] = q30_to_table(taylor_q30(angle, 1'b1));
            cos_lut[j] = q30_to_table(taylor_q30(angle, 1'b0));
         end
         lane_width    = '0;
         stop_dist     = '0;
         step_count    = '0;
         first_hit_idx = '0;
         hit_latched   = 1'b0;
         errors        = 0;
         words_in      = 0;
      endfunction

      // Truncating Taylor series in Q30, twelve terms, clamped at zero.
      function logic [63:0] taylor_q30(logic [63:0] a, logic want_sine);
         logic [63:0] a_sq;
         logic [63:0] term;
         logic [63:0] nfac;
         longint      acc;
         int          k;
         a_sq = (a * a) >> 30;
         term = want_sine ? a : (64'd1 << 30);
         acc  = longint'(term);
         nfac = want_sine ? 64'd1 : 64'd0;
         for (k = 1; k < 12; k++) begin
            term = (term * a_sq) >> 30;
            term = term / ((nfac + 64'd1) * (nfac + 64'd2));
            nfac = nfac + 64'd2;
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         return 64'(acc);
      endfunction

      function logic [sczc_pkg::TRIG_W-1:0] q30_to_table(logic [63:0] v);
         logic [63:0] t;
         t = (v + (64'd1 << (29 - sczc_pkg::TRIG_FRAC_BITS))) >>
             (30 - sczc_pkg::TRIG_FRAC_BITS);
         return t[sczc_pkg::TRIG_W-1:0];
      endfunction

      function void set_reg(logic [sczc_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
         case (idx)
            sczc_pkg::CSR_VEHICLE_WIDTH: begin
               lane_width = val;
            end
            sczc_pkg::CSR_STOP_DISTANCE: begin
               stop_dist = val;
            end
            default: begin
            end
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_word(sczc_pkg::req_payload_type w);
         sczc_pkg::rsp_payload_type  want;
         logic [sczc_pkg::IDX_W-1:0] fold;
         logic                       neg;
         logic [63:0]                r;
         logic [63:0]                xm;
         logic [63:0]                ym;
         r = 64'(w.range_sample & sczc_pkg::RANGE_MASK);
         if (2 * int'(step_count) <= sczc_pkg::SCAN_LAST) begin
            fold = step_count;
            neg  = 1'b0;
         end else begin
            fold = sczc_pkg::IDX_W'(sczc_pkg::SCAN_LAST - int'(step_count));
            neg  = 1'b1;
         end
         ym = (r * 64'(sin_lut[fold]) + (64'd1 << (sczc_pkg::TRIG_FRAC_BITS - 1))) >>
              sczc_pkg::TRIG_FRAC_BITS;
         xm = (r * 64'(cos_lut[fold]) + (64'd1 << (sczc_pkg::TRIG_FRAC_BITS - 1))) >>
              sczc_pkg::TRIG_FRAC_BITS;
         if (ym < 64'(stop_dist) && 2 * xm < 64'(lane_width) && !hit_latched) begin
            hit_latched   = 1'b1;
            first_hit_idx = step_count;
         end
         want.x_coord      = neg ? sczc_pkg::X_W'(-xm) : sczc_pkg::X_W'(xm);
         want.y_coord      = sczc_pkg::RANGE_W'(ym);
         want.sample_index = step_count;
         want.stop_flag    = hit_latched;
         want.hit_index    = hit_latched ? first_hit_idx : '0;
         want.scan_done    = w.last_sample;
         expected_q = {expected_q, want};
         words_in++;
         if (w.last_sample) begin
            step_count    = '0;
            hit_latched   = 1'b0;
            first_hit_idx = '0;
         end else if (int'(step_count) < sczc_pkg::SCAN_LAST) begin
            step_count = step_count + 1'b1;
         end
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         $display("%0t: %s expected %h, got %h", $time, field, want, got);
         errors++;
      endfunction

      function void check_word(sczc_pkg::rsp_payload_type got);
         sczc_pkg::rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (got.x_coord !== want.x_coord) begin
               report("x_coord", 32'(want.x_coord), 32'(got.x_coord));
            end
            if (got.y_coord !== want.y_coord) begin
               report("y_coord", 32'(want.y_coord), 32'(got.y_coord));
            end
            if (got.sample_index !== want.sample_index) begin
               report("sample_index", 32'(want.sample_index), 32'(got.sample_index));
            end
            if (got.stop_flag !== want.stop_flag) begin
               report("stop_flag", 32'(want.stop_flag), 32'(got.stop_flag));
            end
            if (got.hit_index !== want.hit_index) begin
               report("hit_index", 32'(want.hit_index), 32'(got.hit_index));
            end
            if (got.scan_done !== want.scan_done) begin
               report("scan_done", 32'(want.scan_done), 32'(got.scan_done));
            end
         end
      endfunction
   endclass

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   sczc_pkg::req_payload_type           req_payload      = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   sczc_pkg::rsp_payload_type           rsp_payload;
   logic                                csr_write_enable = 1'b0;
   logic [sczc_pkg::CSR_IDX_W-1:0]      csr_index        = '0;
   logic [sczc_pkg::CSR_DATA_W-1:0]     csr_write_data   = '0;

   zone_scoreboard sb;
   int             cycles     = 0;
   int             burst_left = 0;
   int             sent       = 0;
   bit             steady     = 1'b1;

   scan_collision_zone_check dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_word(req_payload);
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_payload);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // The receiver alternates free, periodic and random stall stretches,
   // with occasional long hold-offs that back the block up to its input.
   initial begin : rsp_pacing
      int seg;
      int mode;
      int k;
      bit forced_done;
      forced_done = 1'b0;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 9);
         if (!forced_done && sb.words_in >= 400) mode = 9;
         if (mode == 9) begin
            forced_done = 1'b1;
            seg = $urandom_range(60, 120);
            for (k = 0; k < seg; k++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end else begin
            seg = $urandom_range(4, 40);
            for (k = 0; k < seg; k++) begin
               if (mode <= 2) begin
                  rsp_stall <= 1'b0;
               end else if (mode <= 4) begin
                  rsp_stall <= k[0];
               end else begin
                  rsp_stall <= ($urandom_range(0, 99) < 40);
               end
               @(posedge clock);
            end
         end
      end
   end

   function automatic logic [15:0] pick_range();
      case ($urandom_range(0, 9))
         0: return 16'hFFFF;
         1: return 16'h0000;
         2, 3, 4: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 6000));
      endcase
   endfunction

   task automatic write_reg(input logic [sczc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [15:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic set_zone(input logic [15:0] width, input logic [15:0] stop);
      write_reg(sczc_pkg::CSR_VEHICLE_WIDTH, width);
      write_reg(sczc_pkg::CSR_STOP_DISTANCE, stop);
      write_reg(CSR_SPARE_A, 16'($urandom_range(0, 65535)));
      write_reg(CSR_SPARE_B, 16'($urandom_range(0, 65535)));
      csr_write_enable <= 1'b0;
   endtask

   task automatic offer_word(input logic [15:0] range, input logic last);
      int gap;
      req_valid                <= 1'b1;
      req_payload.range_sample <= range;
      req_payload.last_sample  <= last;
      do @(posedge clock); while (req_stall);
      sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Mostly complete scans; some short, some running past the last angle,
   // and some with the end mark scattered at random.
   task automatic run_scan();
      int pick;
      int len;
      int k;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         len = sczc_pkg::SCAN_POINTS;
      end else if (pick <= 7) begin
         len = $urandom_range(1, 60);
      end else if (pick == 8) begin
         len = $urandom_range(sczc_pkg::SCAN_POINTS + 1, sczc_pkg::SCAN_POINTS + 40);
      end else begin
         len = $urandom_range(1, 40);
      end
      for (k = 0; k < len; k++) begin
         offer_word(pick_range(), (k == len - 1) || (pick == 9 && $urandom_range(0, 7) == 0));
      end
   endtask

   initial begin
      int phase;
      logic [15:0] width;
      logic [15:0] stop;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_zone(16'hFFFF, 16'hFFFF);

      offer_word(16'hFFFF, 1'b1);
      offer_word(16'h0000, 1'b1);
      offer_word(16'h0000, 1'b0);
      offer_word(16'hFFFF, 1'b0);
      offer_word(16'h5555, 1'b0);
      offer_word(16'hAAAA, 1'b0);
      offer_word(16'h8000, 1'b0);
      offer_word(16'h0001, 1'b1);
      offer_word(16'hFFFF, 1'b0);
      offer_word(16'd40000, 1'b0);
      offer_word(16'h0001, 1'b0);
      offer_word(16'h7FFF, 1'b0);
      offer_word(16'h0000, 1'b1);
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin width = 16'd2000;  stop = 16'd3000;  end
            1: begin width = 16'hFFFF;  stop = 16'hFFFF;  end
            2: begin width = 16'h0000;  stop = 16'h0000;  end
            3: begin width = 16'h0000;  stop = 16'hFFFF;  end
            4: begin width = 16'hFFFF;  stop = 16'h0000;  end
            5: begin
               width = 16'($urandom_range(0, 65535));
               stop  = 16'($urandom_range(0, 65535));
            end
            default: begin
               width = 16'($urandom_range(100, 8000));
               stop  = 16'($urandom_range(100, 8000));
            end
         endcase
         set_zone(width, stop);
         steady = (phase == 1);
         sent   = 0;
         while (sent < PHASE_WORDS) begin
            run_scan();
            if ($urandom_range(0, 5) == 0) drain();
         end
         drain();
      end

      repeat (4) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected result words never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
